// ===== src/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and codes of the max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

	// operation codes carried on s_tuser
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// bit positions of the result flags on m_tuser
	localparam int FLAG_VALID    = 0;
	localparam int FLAG_EMPTY    = 1;
	localparam int FLAG_OVERFLOW = 2;
	localparam int FLAG_W        = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_UP_FIN,
		ST_POP_RD,
		ST_DOWN,
		ST_RESULT
	} hpq_state_t;

	typedef struct packed {
		logic overflow;
		logic empty;
		logic valid;
	} hpq_flags_t;

endpackage

// ===== src/hpq_ram.sv =====
// ----------------------------------------------------------------------------
// hpq_ram
// Entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hpq_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [DW-1:0]            rdata_a,
	output logic [DW-1:0]            rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-during-write to the same address returns old data; the
	// controller never uses the data of such a read
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== src/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of (key, handle) entries held in a two-read-port memory.
// ----------------------------------------------------------------------------
// Each input item is a push or a pop and yields exactly one result item.
// One item is worked at a time; s_tready is high only while the sift
// engine is idle, and a finished result sits in an output register so the
// next item can enter while it waits. Reads of the entry memory return
// registered data, and the sift moves one heap level at a time. A push
// climbs up to log2(HEAP_DEPTH) levels and a pop sinks up to
// log2(HEAP_DEPTH) - 1. A push on an empty heap, a refused push and a pop
// on an empty heap go from the idle state straight to the result state;
// a pop that leaves the heap empty passes through the root read state
// first. A result that cannot leave stalls the engine in its result
// state until the output register frees up.
// Sifting uses a hole: the moving entry stays in a register and only the
// displaced entries are written, the moving one lands at the end.
// Keys compare as unsigned integers; on equal child keys the right child
// is taken, and a key moves past a parent only when strictly greater.
// The memory needs no clearing after reset: only data from slots below
// the entry count is ever used.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
	parameter int HEAP_DEPTH   = 1024,
	parameter int KEY_WIDTH    = 32,
	parameter int HANDLE_WIDTH = 16,
	localparam int CW    = $clog2(HEAP_DEPTH + 1),
	localparam int IN_TW = ((KEY_WIDTH + HANDLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_TW = ((KEY_WIDTH + HANDLE_WIDTH + CW + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,  // item_key, item_handle
	input  logic              s_tuser,  // operation
	// result channel
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata,  // out_key, out_handle, entry_count
	output logic [hpq_pkg::FLAG_W-1:0] m_tuser  // out_valid, empty_flag, overflow_flag
);

	localparam int AW  = $clog2(HEAP_DEPTH);
	localparam int KW  = KEY_WIDTH;
	localparam int HW  = HANDLE_WIDTH;
	localparam int EW  = KW + HW;
	localparam int CHW = AW + 2;  // child index, room for 2*pos+2

	// entry layout in memory: key above handle
	function automatic logic [KW-1:0] key_of(input logic [EW-1:0] e);
		return e[EW-1:HW];
	endfunction

	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] a);
		logic [AW-1:0] m1;
		m1 = a - AW'(1);
		return m1 >> 1;
	endfunction

	hpq_pkg::hpq_state_t state_q, state_d;

	logic [CW-1:0] count_q;       // entries held, updated at accept
	logic [AW-1:0] pos_q;         // current hole position
	logic [EW-1:0] mv_q;          // entry being sifted

	// result staging
	hpq_pkg::hpq_flags_t res_flags_q;
	logic [KW-1:0] res_key_q;
	logic [HW-1:0] res_handle_q;

	// output register
	logic                m_tvalid_q;
	hpq_pkg::hpq_flags_t out_flags_q;
	logic [KW-1:0]       out_key_q;
	logic [HW-1:0]       out_handle_q;
	logic [CW-1:0]       out_count_q;

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [AW-1:0] raddr_a, raddr_b;
	logic [EW-1:0] rdata_a, rdata_b;

	hpq_ram #(
		.DEPTH (HEAP_DEPTH),
		.DW    (EW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// input fields
	logic          in_acc;
	logic [KW-1:0] in_key;
	logic [HW-1:0] in_handle;
	logic [EW-1:0] in_entry;
	logic          is_full, is_empty;
	logic          out_free;

	assign in_acc    = s_tvalid && s_tready;
	assign in_key    = s_tdata[KW-1:0];
	assign in_handle = s_tdata[EW-1:KW];
	assign in_entry  = {in_key, in_handle};
	assign is_full   = (count_q == CW'(HEAP_DEPTH));
	assign is_empty  = (count_q == '0);
	assign out_free  = !m_tvalid_q || m_tready;

	// sift-up terms: rdata_a is the parent of pos_q
	logic [AW-1:0] up_par;
	logic          up_gt;
	assign up_par = parent_of(pos_q);
	assign up_gt  = key_of(mv_q) > key_of(rdata_a);

	// sift-down terms: rdata_a / rdata_b are the children of pos_q
	logic [CHW-1:0] lc_w, rc_w, cnt_w;
	logic           lc_ok, rc_ok, take_l, stop_dn;
	logic [EW-1:0]  big;
	logic [AW-1:0]  big_addr;
	logic [CHW-1:0] blc_w, brc_w;

	assign lc_w   = CHW'({pos_q, 1'b1});
	assign rc_w   = lc_w + CHW'(1);
	assign cnt_w  = CHW'(count_q);
	assign lc_ok  = lc_w < cnt_w;
	assign rc_ok  = rc_w < cnt_w;
	assign take_l = !rc_ok || (key_of(rdata_a) > key_of(rdata_b));
	assign big    = take_l ? rdata_a : rdata_b;
	assign big_addr = take_l ? AW'(lc_w) : AW'(rc_w);
	assign stop_dn  = !lc_ok || (key_of(mv_q) >= key_of(big));
	assign blc_w    = CHW'({big_addr, 1'b1});
	assign brc_w    = blc_w + CHW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hpq_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser == hpq_pkg::OP_PUSH) begin
						state_d = (is_full || is_empty) ? hpq_pkg::ST_RESULT
						                                : hpq_pkg::ST_UP;
					end else begin
						state_d = is_empty ? hpq_pkg::ST_RESULT : hpq_pkg::ST_POP_RD;
					end
				end
			end
			hpq_pkg::ST_UP: begin
				if (!up_gt) begin
					state_d = hpq_pkg::ST_RESULT;
				end else if (up_par == '0) begin
					state_d = hpq_pkg::ST_UP_FIN;
				end
			end
			hpq_pkg::ST_UP_FIN: state_d = hpq_pkg::ST_RESULT;
			hpq_pkg::ST_POP_RD: begin
				state_d = (count_q == '0) ? hpq_pkg::ST_RESULT : hpq_pkg::ST_DOWN;
			end
			hpq_pkg::ST_DOWN: begin
				if (stop_dn) begin
					state_d = hpq_pkg::ST_RESULT;
				end
			end
			hpq_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = hpq_pkg::ST_IDLE;
				end
			end
			default: state_d = hpq_pkg::ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = mv_q;
		raddr_a   = '0;
		raddr_b   = '0;
		case (state_q)
			hpq_pkg::ST_IDLE: begin
				if (in_acc && s_tuser == hpq_pkg::OP_PUSH) begin
					// empty heap: entry goes straight to the root
					mem_we    = !is_full && is_empty;
					mem_waddr = '0;
					mem_wdata = in_entry;
					raddr_a   = parent_of(AW'(count_q));
				end else begin
					raddr_a = '0;
					raddr_b = AW'(count_q - CW'(1));  // last entry
				end
			end
			hpq_pkg::ST_UP: begin
				mem_we    = 1'b1;
				mem_wdata = up_gt ? rdata_a : mv_q;
				raddr_a   = parent_of(up_par);
			end
			hpq_pkg::ST_UP_FIN: begin
				mem_we = 1'b1;
			end
			hpq_pkg::ST_POP_RD: begin
				raddr_a = AW'(1);
				raddr_b = AW'(2);
			end
			hpq_pkg::ST_DOWN: begin
				mem_we    = 1'b1;
				mem_wdata = stop_dn ? mv_q : big;
				raddr_a   = AW'(blc_w);
				raddr_b   = AW'(brc_w);
			end
			hpq_pkg::ST_RESULT: ;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hpq_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == hpq_pkg::ST_IDLE && in_acc) begin
				if (s_tuser == hpq_pkg::OP_PUSH && !is_full) begin
					count_q <= count_q + CW'(1);
				end else if (s_tuser == hpq_pkg::OP_POP && !is_empty) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// sift datapath and result staging
	always_ff @(posedge clk) begin
		case (state_q)
			hpq_pkg::ST_IDLE: begin
				if (in_acc) begin
					mv_q               <= in_entry;
					pos_q              <= AW'(count_q);
					res_key_q          <= '0;
					res_handle_q       <= '0;
					res_flags_q.valid  <= 1'b0;
					res_flags_q.empty  <= (s_tuser == hpq_pkg::OP_POP) && is_empty;
					res_flags_q.overflow <= (s_tuser == hpq_pkg::OP_PUSH) && is_full;
				end
			end
			hpq_pkg::ST_UP: begin
				if (up_gt) begin
					pos_q <= up_par;
				end
			end
			hpq_pkg::ST_POP_RD: begin
				res_key_q         <= key_of(rdata_a);
				res_handle_q      <= rdata_a[HW-1:0];
				res_flags_q.valid <= 1'b1;
				mv_q              <= rdata_b;
				pos_q             <= '0;
			end
			hpq_pkg::ST_DOWN: begin
				if (!stop_dn) begin
					pos_q <= big_addr;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == hpq_pkg::ST_RESULT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hpq_pkg::ST_RESULT && out_free) begin
			out_flags_q  <= res_flags_q;
			out_key_q    <= res_key_q;
			out_handle_q <= res_handle_q;
			out_count_q  <= count_q;
		end
	end

	assign s_tready = (state_q == hpq_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TW'({out_count_q, out_handle_q, out_key_q});
	assign m_tuser  = {out_flags_q.overflow, out_flags_q.empty, out_flags_q.valid};

endmodule
